// ===== hdl/utf8kv_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8kv_pkg
// Shared types, constants and check functions of the UTF-8 key validator.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8kv_pkg;

    // Verdict codes, reported in the result transaction
    typedef enum logic [2:0] {
        REASON_OK     = 3'd0,
        REASON_EMPTY  = 3'd1,
        REASON_FIRST  = 3'd2,
        REASON_LEAD   = 3'd3,
        REASON_CONT   = 3'd4,
        REASON_RANGE  = 3'd5,
        REASON_FORBID = 3'd6,
        REASON_SPACE  = 3'd7
    } reason_t;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned M_DATA_W = 8;

    localparam logic [BYTE_W-1:0] BYTE_NUL     = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_HASH    = 8'h23;
    localparam logic [BYTE_W-1:0] BYTE_SEMI    = 8'h3B;
    localparam logic [BYTE_W-1:0] BYTE_BRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CONT_MASK    = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG     = 8'h80;

    typedef logic [CP_W-1:0] cp_t;

    // Overlong, surrogate and above-range forms, decided on the second byte
    function automatic logic out_of_range(input logic [BYTE_W-1:0] lead,
                                          input logic [BYTE_W-1:0] second);
        logic r;
        r = 1'b0;
        if (lead == 8'hE0 && second < 8'hA0) r = 1'b1;
        if (lead == 8'hED && second >= 8'hA0) r = 1'b1;
        if (lead == 8'hF0 && second < 8'h90) r = 1'b1;
        if (lead == 8'hF4 && second >= 8'h90) r = 1'b1;
        return r;
    endfunction

    // Control characters, line and paragraph separators and '='
    function automatic logic is_forbidden(input cp_t cp);
        logic r;
        r = 1'b0;
        if (cp < 21'h20) r = 1'b1;
        if (cp >= 21'h7F && cp <= 21'h9F) r = 1'b1;
        if (cp == 21'h2028 || cp == 21'h2029) r = 1'b1;
        if (cp == 21'h3D) r = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/utf8_key_validator.sv =====
// ----------------------------------------------------------------------------
// utf8_key_validator
// Streaming checker for zero-terminated keys: strict UTF-8 plus key rules.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the key one byte per transaction on the s_ channel (s_tdata). A zero
//   byte ends the key; only that byte produces a result transaction on the
//   m_ channel, carrying key_ok and fail_reason. Other bytes produce nothing.
//   The verdict appears on m_tvalid in the cycle after the terminator
//   is accepted. Throughput: one byte per clock, sustained, as long as the
//   result side keeps up; the single output register lets the next key's
//   bytes stream in while a verdict is being taken.
//   The per-byte decode state (open sequence, code point, first-error latch)
//   sits in registers and is updated in the cycle a byte is accepted, so
//   each byte passes through one level of compare and shift logic only.
//   Stall: while a verdict is held in the output register and m_tready is
//   low, s_tready drops and no byte is accepted.
//   Reset (aresetn low, synchronous): the block is ready for a new key, with
//   no verdict pending and no error latched.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_key_validator (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // s_tdata: [7:0] key_byte
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [utf8kv_pkg::BYTE_W-1:0]      s_tdata,
    // m_tdata: [0] key_ok, [3:1] fail_reason, [7:4] zero
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [utf8kv_pkg::M_DATA_W-1:0]         m_tdata
);
    import utf8kv_pkg::*;

    // Decode state
    logic [BYTE_W-1:0] lead_value_reg,     lead_value_next;
    logic [1:0]        bytes_left_reg,     bytes_left_next;
    logic [1:0]        seq_position_reg,   seq_position_next;
    cp_t               code_accum_reg,     code_accum_next;
    logic              at_key_start_reg,   at_key_start_next;
    logic              prev_was_space_reg, prev_was_space_next;
    reason_t           latched_error_reg,  latched_error_next;

    // Result register
    logic              m_valid_reg,  m_valid_next;
    logic              key_ok_reg,   key_ok_next;
    reason_t           reason_reg,   reason_next;

    logic              s_accept;
    logic              is_term;
    reason_t           verdict;
    cp_t               cp;
    cp_t               accum_shifted;
    logic              char_done;

    // The output register frees up when its content is taken
    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign is_term  = (s_tdata == BYTE_NUL);

    assign accum_shifted = {code_accum_reg[CP_W-7:0], s_tdata[5:0]};

    // Verdict for the terminator: first latched error wins
    always_comb begin
        verdict = latched_error_reg;
        if (latched_error_reg == REASON_OK) begin
            if (at_key_start_reg) verdict = REASON_EMPTY;
            else if (bytes_left_reg != 2'd0) verdict = REASON_CONT;
            else if (prev_was_space_reg) verdict = REASON_SPACE;
            else verdict = REASON_OK;
        end
    end

    always_comb begin
        lead_value_next     = lead_value_reg;
        bytes_left_next     = bytes_left_reg;
        seq_position_next   = seq_position_reg;
        code_accum_next     = code_accum_reg;
        at_key_start_next   = at_key_start_reg;
        prev_was_space_next = prev_was_space_reg;
        latched_error_next  = latched_error_reg;
        m_valid_next        = m_valid_reg && !m_tready;
        key_ok_next         = key_ok_reg;
        reason_next         = reason_reg;
        cp                  = cp_t'(s_tdata);
        char_done           = 1'b0;

        if (s_accept) begin
            if (is_term) begin
                // Emit the verdict and return to the start of a key
                m_valid_next        = 1'b1;
                key_ok_next         = (verdict == REASON_OK);
                reason_next         = verdict;
                lead_value_next     = '0;
                bytes_left_next     = 2'd0;
                seq_position_next   = 2'd0;
                code_accum_next     = '0;
                at_key_start_next   = 1'b1;
                prev_was_space_next = 1'b0;
                latched_error_next  = REASON_OK;
            end else begin
                at_key_start_next = 1'b0;
                if (latched_error_reg == REASON_OK) begin
                    if (bytes_left_reg == 2'd0) begin
                        if (at_key_start_reg && (s_tdata inside
                                {BYTE_SPACE, BYTE_HASH, BYTE_SEMI, BYTE_BRACKET})) begin
                            latched_error_next = REASON_FIRST;
                        end else if (s_tdata inside {[8'h01:8'h7F]}) begin
                            char_done = 1'b1;
                        end else if (s_tdata inside {[8'hC2:8'hDF]}) begin
                            lead_value_next   = s_tdata;
                            code_accum_next   = cp_t'(s_tdata[4:0]);
                            bytes_left_next   = 2'd1;
                            seq_position_next = 2'd1;
                        end else if (s_tdata inside {[8'hE0:8'hEF]}) begin
                            lead_value_next   = s_tdata;
                            code_accum_next   = cp_t'(s_tdata[3:0]);
                            bytes_left_next   = 2'd2;
                            seq_position_next = 2'd1;
                        end else if (s_tdata inside {[8'hF0:8'hF4]}) begin
                            lead_value_next   = s_tdata;
                            code_accum_next   = cp_t'(s_tdata[2:0]);
                            bytes_left_next   = 2'd3;
                            seq_position_next = 2'd1;
                        end else begin
                            latched_error_next = REASON_LEAD;
                        end
                    end else begin
                        if ((s_tdata & CONT_MASK) != CONT_TAG) begin
                            latched_error_next = REASON_CONT;
                        end else if (seq_position_reg == 2'd1 &&
                                     out_of_range(lead_value_reg, s_tdata)) begin
                            latched_error_next = REASON_RANGE;
                        end else begin
                            code_accum_next   = accum_shifted;
                            bytes_left_next   = bytes_left_reg - 2'd1;
                            seq_position_next = seq_position_reg + 2'd1;
                            cp                = accum_shifted;
                            char_done         = (bytes_left_reg == 2'd1);
                        end
                    end

                    // Close a finished character and apply the character rules
                    if (char_done) begin
                        seq_position_next = 2'd0;
                        if (is_forbidden(cp)) begin
                            latched_error_next = REASON_FORBID;
                        end else begin
                            prev_was_space_next = (cp == cp_t'(BYTE_SPACE));
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_value_reg     <= '0;
            bytes_left_reg     <= 2'd0;
            seq_position_reg   <= 2'd0;
            code_accum_reg     <= '0;
            at_key_start_reg   <= 1'b1;
            prev_was_space_reg <= 1'b0;
            latched_error_reg  <= REASON_OK;
            m_valid_reg        <= 1'b0;
        end else begin
            lead_value_reg     <= lead_value_next;
            bytes_left_reg     <= bytes_left_next;
            seq_position_reg   <= seq_position_next;
            code_accum_reg     <= code_accum_next;
            at_key_start_reg   <= at_key_start_next;
            prev_was_space_reg <= prev_was_space_next;
            latched_error_reg  <= latched_error_next;
            m_valid_reg        <= m_valid_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge aclk) begin
        key_ok_reg <= key_ok_next;
        reason_reg <= reason_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W-4)'(0), reason_reg, key_ok_reg};

    // A terminator always leaves the decoder at the start of a clean key
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && is_term) |=> (at_key_start_reg && latched_error_reg == REASON_OK
                                   && bytes_left_reg == 2'd0))
        else $error("decode state not cleared after terminator");

    // key_ok and fail_reason must agree
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (key_ok_reg == (reason_reg == REASON_OK)))
        else $error("key_ok disagrees with fail_reason");

    // An open sequence always has a position inside it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (bytes_left_reg != 2'd0) |-> (seq_position_reg != 2'd0))
        else $error("open sequence without position");

    // The first error holds until the key ends
    assert property (@(posedge aclk) disable iff (!aresetn)
        (latched_error_reg != REASON_OK && !(s_accept && is_term))
            |=> $stable(latched_error_reg))
        else $error("latched error overwritten inside a key");

    // A verdict is only produced by an accepted terminator
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s_accept && is_term))
        else $error("result without terminator");

endmodule

`default_nettype wire
